// ----- hdl/state_space_pendulum_controller_defines.svh -----
// ----------------------------------------------------------------------------
// State space pendulum controller: assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STATE_SPACE_PENDULUM_CONTROLLER_DEFINES_SVH
`define STATE_SPACE_PENDULUM_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SSPC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sspc check failed");

// next-cycle implication
`define SSPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sspc check failed");

`endif

// ----- hdl/sspc_pkg.sv -----
// ----------------------------------------------------------------------------
// sspc_pkg
// Types, register map and fixed constants of the pendulum controller.
// ----------------------------------------------------------------------------
package sspc_pkg;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam int CMD_LIMIT_W = 20;
	localparam int ANG_LIMIT_W = 17;
	localparam int POS_LIMIT_W = 20;

	localparam logic [CMD_LIMIT_W-1:0] CMD_LIMIT_RST = 20'd622592;
	localparam logic [ANG_LIMIT_W-1:0] ANG_LIMIT_RST = 17'd20972;
	localparam logic [POS_LIMIT_W-1:0] POS_LIMIT_RST = 20'd524288;

	typedef enum logic [1:0] {
		REG_COMMAND_LIMIT  = 2'd0,
		REG_ANGLE_LIMIT    = 2'd1,
		REG_POSITION_LIMIT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CMD_LIMIT_W-1:0] command_limit;
		logic [ANG_LIMIT_W-1:0] angle_limit;
		logic [POS_LIMIT_W-1:0] position_limit;
	} cfg_t;

	// shared multiplier and value widths
	localparam int MUL_W = 32;
	localparam int VAL_W = 32;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

	// converter scaling: 1.08 = 27/25, 0.435 = 87/200
	localparam int POS_GAIN = 27;
	localparam int ANG_GAIN = 87;
	localparam int DIV_BASE = 25;

	// reciprocal multiply for /25 (operand below 2^29) and /5 (below 2^26)
	localparam logic signed [MUL_W-1:0] RECIP25       = 32'sd1374389535;
	localparam int                      RECIP25_SHIFT = 35;
	localparam logic signed [MUL_W-1:0] RECIP5        = 32'sd107374183;
	localparam int                      RECIP5_SHIFT  = 29;
	// offset keeps the DAC dividend positive: 5 * 2^23, quotient offset 2^23
	localparam logic signed [MUL_W-1:0] DAC_BIAS      = 32'sd41943040;
	localparam logic signed [MUL_W-1:0] DAC_BIAS_Q    = 32'sd8388608;

	localparam int NUM_STATES = 4;
	localparam int NUM_ROWS   = 5;
	localparam int NUM_COLS   = 6;

	// coefficients in units of 1e-4; rows x1..x4 then drive, cols x1..x4, angle, position
	localparam int COEF_E4 [NUM_ROWS][NUM_COLS] = '{
		'{6300, -1206, -8, 86, 3658, 1200},
		'{-953, 6935, 107, 12, 993, 3070},
		'{-2896, -19184, 11306, 2351, 10887, 20141},
		'{-39680, -17733, -1546, 7222, 31377, 16599},
		'{-803092, -96237, -141215, -236260, 0, 0}
	};

	typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][MUL_W-1:0] coef_tab_t;

	// round(c * 2^frac), half away from zero
	function automatic coef_tab_t coef_table(int frac);
		coef_tab_t tab;
		longint    m;
		longint    q;
		tab = '0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				m = (COEF_E4[r][c] < 0) ? -longint'(COEF_E4[r][c]) : longint'(COEF_E4[r][c]);
				q = (m * (longint'(1) << frac) + 64'sd5000) / 64'sd10000;
				tab[r][c] = MUL_W'((COEF_E4[r][c] < 0) ? -q : q);
			end
		end
		return tab;
	endfunction

endpackage

// ----- hdl/sspc_if.sv -----
// ----------------------------------------------------------------------------
// sspc_if
// Valid/ready channels: measurement beats in, DAC command beats out.
// ----------------------------------------------------------------------------
interface sspc_meas_if #(
	parameter int CODE_BITS = 12
);
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] pos_code;
	logic [CODE_BITS-1:0] angle_code;

	modport source (output valid, output pos_code, output angle_code, input ready);
	modport sink   (input valid, input pos_code, input angle_code, output ready);
endinterface

interface sspc_cmd_if #(
	parameter int CODE_BITS = 12
);
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] dac_code;

	modport source (output valid, output dac_code, input ready);
	modport sink   (input valid, input dac_code, output ready);
endinterface

// ----- hdl/sspc_apb_regs.sv -----
// ----------------------------------------------------------------------------
// sspc_apb_regs
// APB register file holding the drive clamp and the two safety limits.
// ----------------------------------------------------------------------------
module sspc_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sspc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sspc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sspc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output sspc_pkg::cfg_t                   cfg
);
	import sspc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_limit  <= CMD_LIMIT_RST;
			cfg_q.angle_limit    <= ANG_LIMIT_RST;
			cfg_q.position_limit <= POS_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_COMMAND_LIMIT:  cfg_q.command_limit  <= pwdata[CMD_LIMIT_W-1:0];
				REG_ANGLE_LIMIT:    cfg_q.angle_limit    <= pwdata[ANG_LIMIT_W-1:0];
				REG_POSITION_LIMIT: cfg_q.position_limit <= pwdata[POS_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COMMAND_LIMIT:  prdata = APB_DATA_W'(cfg_q.command_limit);
			REG_ANGLE_LIMIT:    prdata = APB_DATA_W'(cfg_q.angle_limit);
			REG_POSITION_LIMIT: prdata = APB_DATA_W'(cfg_q.position_limit);
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- hdl/sspc_mult.sv -----
// ----------------------------------------------------------------------------
// sspc_mult
// Shared signed 32x32 multiplier with registered product and load enable.
// ----------------------------------------------------------------------------
module sspc_mult (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [sspc_pkg::MUL_W-1:0]    a,
	input  logic signed [sspc_pkg::MUL_W-1:0]    b,
	output logic signed [2*sspc_pkg::MUL_W-1:0]  p
);
	import sspc_pkg::*;

	logic signed [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule

// ----- hdl/state_space_pendulum_controller.sv -----
// ----------------------------------------------------------------------------
// state_space_pendulum_controller
// Observer-based inverted pendulum controller on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   meas carries one beat per control sample: pos_code and angle_code,
//   offset binary with half scale at centre/upright. cmd returns one beat
//   per sample: dac_code, offset binary with half scale meaning zero drive.
//   The APB port sets the drive clamp and the angle and position limits;
//   write it only while no sample is in flight.
// Sequence:
//   An accepted sample steps through S_POS and S_ANG (2 scaling products),
//   S_MAC (28 observer and drive products), S_ACC and S_WB to drain the
//   accumulator, S_DAC (1 DAC product) and S_DONE to load the cmd register,
//   then returns to S_IDLE for the next beat. All products share the single
//   32x32 multiplier; no new sample is taken before the last is through.
//   meas.ready is high only while no sample is being worked.
// Reset: observer state clears to zero, limits return to their defaults.
// Stall: the result waits in the cmd output register; a new sample is still
//   accepted, and its own result holds in the last step until cmd frees.
// ----------------------------------------------------------------------------
module state_space_pendulum_controller #(
	parameter int FRAC_BITS = 16,
	parameter int CODE_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sspc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sspc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sspc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	sspc_meas_if.sink                        meas,
	sspc_cmd_if.source                       cmd
);
	import sspc_pkg::*;

	localparam int ACC_W = 2*MUL_W + 3;
	localparam int XW    = MUL_W - 1;
	localparam int NW    = CODE_BITS + 8 + FRAC_BITS;
	localparam int DRV_W = CMD_LIMIT_W + 1;
	localparam int DAC_W = DRV_W + CODE_BITS;

	localparam coef_tab_t COEF = coef_table(FRAC_BITS);

	localparam logic [2:0] ROW_DRIVE      = 3'd4;
	localparam logic [2:0] COL_ANG        = 3'd4;
	localparam logic [2:0] COL_POS        = 3'd5;
	localparam logic [2:0] COL_OBS_LAST   = 3'd5;
	localparam logic [2:0] COL_DRIVE_LAST = 3'd3;

	localparam logic [CODE_BITS-1:0]    HALF_U      = CODE_BITS'(1) << (CODE_BITS-1);
	localparam logic signed [MUL_W-1:0] HALF_CODE_S = MUL_W'(1 << (CODE_BITS-1));
	localparam logic signed [MUL_W-1:0] CODE_MAX_S  = MUL_W'((1 << CODE_BITS) - 1);
	localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(longint'(1) << (FRAC_BITS-1));

	typedef enum logic [2:0] {
		S_IDLE, S_POS, S_ANG, S_MAC, S_ACC, S_WB, S_DAC, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_POS, OP_ANG, OP_MAC, OP_DAC
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [2:0] row;
		logic       first;
		logic       last;
	} issue_t;

	cfg_t cfg;

	sspc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t                    state_q;
	logic [2:0]                row_q;
	logic [2:0]                col_q;
	logic                      out_valid_q;
	issue_t                    tag_s2;
	logic                      wb_valid_s3;
	logic [2:0]                wb_row_s3;
	logic signed [VAL_W-1:0]   x_q  [NUM_STATES];
	logic signed [VAL_W-1:0]   nx_q [NUM_STATES];

	logic [XW-1:0]             xpos_q;
	logic [XW-1:0]             xang_q;
	logic                      pos_neg_q;
	logic                      ang_neg_q;
	logic signed [VAL_W-1:0]   pos_q;
	logic signed [VAL_W-1:0]   ang_q;
	logic                      pos_over_q;
	logic                      ang_over_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DRV_W-1:0]   drive_q;
	logic [CODE_BITS-1:0]      dac_code_q;

	// input scaling
	logic [CODE_BITS-1:0] pos_mag;
	logic [CODE_BITS-1:0] ang_mag;
	logic [NW-1:0]        pos_num;
	logic [NW-1:0]        ang_num;
	logic [XW-1:0]        pos_x;
	logic [XW-1:0]        ang_x;

	assign pos_mag = meas.pos_code[CODE_BITS-1] ? (meas.pos_code - HALF_U)
	                                            : (HALF_U - meas.pos_code);
	assign ang_mag = meas.angle_code[CODE_BITS-1] ? (meas.angle_code - HALF_U)
	                                              : (HALF_U - meas.angle_code);
	assign pos_num = ((NW'(pos_mag) * NW'(POS_GAIN)) << FRAC_BITS)
	               + (NW'(DIV_BASE) << (CODE_BITS-2));
	assign ang_num = ((NW'(ang_mag) * NW'(ANG_GAIN)) << FRAC_BITS)
	               + (NW'(DIV_BASE) << (CODE_BITS+1));
	assign pos_x   = XW'(pos_num >> (CODE_BITS-1));
	assign ang_x   = XW'(ang_num >> (CODE_BITS+2));

	// operand selection
	issue_t                    iss;
	logic signed [MUL_W-1:0]   op_a;
	logic signed [MUL_W-1:0]   op_b;
	logic signed [MUL_W-1:0]   val_sel;
	logic [2:0]                col_last;
	logic signed [DRV_W-1:0]   drive_eff;
	logic signed [DAC_W-1:0]   dac_scaled;
	logic signed [MUL_W-1:0]   dac_z;

	assign col_last   = (row_q == ROW_DRIVE) ? COL_DRIVE_LAST : COL_OBS_LAST;
	assign drive_eff  = (ang_over_q || pos_over_q) ? '0 : drive_q;
	assign dac_scaled = (DAC_W'(drive_eff) <<< (CODE_BITS-1)) >>> (FRAC_BITS+1);
	assign dac_z      = MUL_W'(dac_scaled) + DAC_BIAS;

	always_comb begin
		case (col_q)
			COL_ANG: val_sel = ang_q;
			COL_POS: val_sel = pos_q;
			default: val_sel = x_q[col_q[1:0]];
		endcase
	end

	always_comb begin
		iss  = '{kind: OP_NONE, row: row_q, first: 1'b0, last: 1'b0};
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_POS: begin
				iss.kind = OP_POS;
				op_a     = {1'b0, xpos_q};
				op_b     = RECIP25;
			end
			S_ANG: begin
				iss.kind = OP_ANG;
				op_a     = {1'b0, xang_q};
				op_b     = RECIP25;
			end
			S_MAC: begin
				iss.kind  = OP_MAC;
				iss.first = (col_q == 3'd0);
				iss.last  = (col_q == col_last);
				op_a      = $signed(COEF[row_q][col_q]);
				op_b      = val_sel;
			end
			S_DAC: begin
				iss.kind = OP_DAC;
				op_a     = dac_z;
				op_b     = RECIP5;
			end
			default: ;
		endcase
	end

	logic signed [2*MUL_W-1:0] prod;

	sspc_mult u_mult (
		.clk (clk),
		.en  (iss.kind != OP_NONE),
		.a   (op_a),
		.b   (op_b),
		.p   (prod)
	);

	// product consumers
	logic signed [MUL_W-1:0]   scale_q;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic                      sat_ovf;
	logic signed [VAL_W-1:0]   row_sat;
	logic signed [ACC_W-1:0]   lim_ext;
	logic signed [DRV_W-1:0]   drive_clamped;
	logic signed [MUL_W-1:0]   dac_q5;
	logic signed [MUL_W-1:0]   dac_full;
	logic [CODE_BITS-1:0]      dac_code_next;
	logic                      out_take;

	assign scale_q  = MUL_W'(prod >>> RECIP25_SHIFT);
	assign prod_ext = ACC_W'(prod);
	assign acc_rnd  = (acc_q + ROUND_HALF) >>> FRAC_BITS;
	assign sat_ovf  = acc_rnd[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){acc_rnd[ACC_W-1]}};
	assign row_sat  = sat_ovf ? (acc_rnd[ACC_W-1] ? VAL_MIN : VAL_MAX) : acc_rnd[VAL_W-1:0];
	assign lim_ext  = ACC_W'(cfg.command_limit);

	always_comb begin
		if (acc_rnd > lim_ext) begin
			drive_clamped = DRV_W'(lim_ext);
		end else if (acc_rnd < -lim_ext) begin
			drive_clamped = DRV_W'(-lim_ext);
		end else begin
			drive_clamped = DRV_W'(acc_rnd);
		end
	end

	assign dac_q5   = MUL_W'(prod >>> RECIP5_SHIFT);
	assign dac_full = dac_q5 - DAC_BIAS_Q + HALF_CODE_S;

	always_comb begin
		if (dac_full < 0) begin
			dac_code_next = '0;
		end else if (dac_full > CODE_MAX_S) begin
			dac_code_next = '1;
		end else begin
			dac_code_next = dac_full[CODE_BITS-1:0];
		end
	end

	assign out_take = (state_q == S_DONE) && (!out_valid_q || cmd.ready);

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			tag_s2      <= '0;
			wb_valid_s3 <= 1'b0;
			wb_row_s3   <= '0;
			for (int i = 0; i < NUM_STATES; i++) begin
				x_q[i] <= '0;
			end
		end else begin
			tag_s2      <= iss;
			wb_valid_s3 <= (tag_s2.kind == OP_MAC) && tag_s2.last;
			wb_row_s3   <= tag_s2.row;
			out_valid_q <= out_take || (out_valid_q && !cmd.ready);
			case (state_q)
				S_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					if (meas.valid) begin
						state_q <= S_POS;
					end
				end
				S_POS: state_q <= S_ANG;
				S_ANG: state_q <= S_MAC;
				S_MAC: begin
					if (iss.last) begin
						col_q <= '0;
						if (row_q == ROW_DRIVE) begin
							state_q <= S_ACC;
						end else begin
							row_q <= row_q + 3'd1;
						end
					end else begin
						col_q <= col_q + 3'd1;
					end
				end
				S_ACC: state_q <= S_WB;
				S_WB:  state_q <= S_DAC;
				S_DAC: begin
					for (int i = 0; i < NUM_STATES; i++) begin
						x_q[i] <= nx_q[i];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && meas.valid) begin
			xpos_q    <= pos_x;
			xang_q    <= ang_x;
			pos_neg_q <= !meas.pos_code[CODE_BITS-1];
			ang_neg_q <= !meas.angle_code[CODE_BITS-1];
		end
		case (tag_s2.kind)
			OP_POS: begin
				pos_q      <= pos_neg_q ? -scale_q : scale_q;
				pos_over_q <= $unsigned(scale_q) > MUL_W'(cfg.position_limit);
			end
			OP_ANG: begin
				ang_q      <= ang_neg_q ? -scale_q : scale_q;
				ang_over_q <= $unsigned(scale_q) > MUL_W'(cfg.angle_limit);
			end
			OP_MAC: acc_q <= tag_s2.first ? prod_ext : (acc_q + prod_ext);
			default: ;
		endcase
		if (wb_valid_s3) begin
			if (wb_row_s3 == ROW_DRIVE) begin
				drive_q <= drive_clamped;
			end else begin
				nx_q[wb_row_s3[1:0]] <= row_sat;
			end
		end
		if (out_take) begin
			dac_code_q <= dac_code_next;
		end
	end

	assign meas.ready   = (state_q == S_IDLE);
	assign cmd.valid    = out_valid_q;
	assign cmd.dac_code = dac_code_q;

endmodule

// ----- hdl/sspc_checker.sv -----
// ----------------------------------------------------------------------------
// sspc_checker
// Port-level checks of the pendulum controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "state_space_pendulum_controller_defines.svh"

module sspc_checker #(
	parameter int CODE_BITS = 12
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 meas_valid,
	input logic                 meas_ready,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input logic [CODE_BITS-1:0] cmd_dac_code
);

	// a sample keeps the block busy
	`SSPC_ASSERT_NEXT(a_busy_after_beat, meas_valid && meas_ready, !meas_ready)

	// a result only appears at the end of a busy period
	`SSPC_ASSERT_IMPL(a_result_after_work, $rose(cmd_valid), !$past(meas_ready))

	// stalled result beat holds
	`SSPC_ASSERT_NEXT(a_cmd_valid_hold, cmd_valid && !cmd_ready, cmd_valid)
	`SSPC_ASSERT_NEXT(a_cmd_data_hold, cmd_valid && !cmd_ready, $stable(cmd_dac_code))

endmodule

bind state_space_pendulum_controller sspc_checker #(
	.CODE_BITS (CODE_BITS)
) u_sspc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.meas_valid   (meas.valid),
	.meas_ready   (meas.ready),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_dac_code (cmd.dac_code)
);
